[src/pidc_pkg.sv]
package pidc_pkg;

   // register indexes on the csr channel
   localparam int unsigned CsrIdxW = 3;
   localparam logic [CsrIdxW-1:0] REG_GAIN_PROP  = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_GAIN_INTEG = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_GAIN_DERIV = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_OUT_UPPER  = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_OUT_LOWER  = 3'd4;

   localparam logic [15:0] DT_ONE = 16'd4096;   // 1.0 in Q4.12

   // |error delta| * 4096 fits in 28 bits
   localparam int unsigned DivW    = 28;
   localparam int unsigned DivCntW = 5;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

[src/pid_controller_clamped.sv]
// channel | dir | ports                          | word
// req     | in  | req_tvalid/tready/tdata[31:0]  | [15:0] error_sample, [31:16] step_time
// rsp     | out | rsp_tvalid/tready/tdata[15:0]  | [15:0] drive
// csr     | in  | csr_valid/ready/index/data     | index 0..4, data 16 bit
//
// From accept to result, one word goes through one multiply for the integral
// step, the bit-serial divider for the derivative, then three
// products through the one shared 16x32 multiplier and the accumulate.
// req_tready is high only while idle; a result waits in the output register
// while the next word is taken. Synchronous reset clears the error history,
// the integral and the registers to their defaults. csr_ready is always high.
module pid_controller_clamped (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [15:0] error_sample, [31:16] step_time
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [15:0] drive
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [pidc_pkg::CsrIdxW-1:0] csr_index,
   input  logic [15:0] csr_data
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_INC   = 4'd1;
   localparam logic [3:0] ST_INTEG = 4'd2;
   localparam logic [3:0] ST_DIV   = 4'd3;
   localparam logic [3:0] ST_MP    = 4'd4;
   localparam logic [3:0] ST_MI    = 4'd5;
   localparam logic [3:0] ST_MD    = 4'd6;
   localparam logic [3:0] ST_SUM   = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;

   logic [3:0]         state_ff, state_in;
   logic signed [15:0] gain_prop_ff, gain_integ_ff, gain_deriv_ff;
   logic signed [15:0] out_upper_ff, out_lower_ff;
   logic signed [15:0] err_ff, err_in;
   logic [15:0]        dt_ff, dt_in;
   logic signed [16:0] diff_ff, diff_in;
   logic signed [15:0] prev_err_ff, prev_err_in;
   logic signed [31:0] integ_ff, integ_in;
   logic signed [47:0] prod_ff, prod_in;
   logic signed [49:0] acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_data_ff, rsp_data_in;

   logic signed [15:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [47:0] mul_p;

   logic                         req_take;
   logic                         div_start;
   logic [15:0]                  diff_mag;
   logic [pidc_pkg::DivW-1:0]    div_quot;
   pidc_pkg::div_status_type     div_stat;
   logic signed [28:0]           deriv;
   logic signed [36:0]           integ_sum;
   logic signed [50:0]           ctl_neg;
   logic signed [42:0]           ctl;
   logic                         out_load;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // |diff| <= 65535, so the magnitude fits 16 bits
   assign diff_mag = 16'(diff_ff[16] ? -diff_ff : diff_ff);

   pidc_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    ({diff_mag, 12'd0}),
      .den    (dt_ff),
      .quot   (div_quot),
      .status (div_stat)
   );

   // quotient truncates toward zero: divide magnitudes, restore sign
   assign deriv = diff_ff[16] ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});

   always_comb begin
      case (state_ff)
         ST_INC: begin
            mul_a = err_ff;
            mul_b = $signed({16'd0, dt_ff});
         end
         ST_MI: begin
            mul_a = gain_integ_ff;
            mul_b = integ_ff;
         end
         ST_MD: begin
            mul_a = gain_deriv_ff;
            mul_b = 32'(deriv);
         end
         default: begin
            mul_a = gain_prop_ff;
            mul_b = 32'(err_ff);
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // integral step is floor(e*dt / 4096)
   assign integ_sum = 37'(integ_ff) + 37'(prod_ff >>> 12);

   assign ctl_neg  = -51'(acc_ff);
   assign ctl      = 43'(ctl_neg >>> 8);
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      err_in       = err_ff;
      dt_in        = dt_ff;
      diff_in      = diff_ff;
      prev_err_in  = prev_err_ff;
      integ_in     = integ_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               err_in      = $signed(req_tdata[15:0]);
               dt_in       = (req_tdata[31:16] == '0) ? pidc_pkg::DT_ONE : req_tdata[31:16];
               diff_in     = 17'($signed(req_tdata[15:0])) - 17'(prev_err_ff);
               prev_err_in = $signed(req_tdata[15:0]);
               state_in    = ST_INC;
            end
         end
         ST_INC: begin
            prod_in  = mul_p;
            state_in = ST_INTEG;
         end
         ST_INTEG: begin
            if (integ_sum > 37'sd2147483647)
               integ_in = 32'sh7fffffff;
            else if (integ_sum < -37'sd2147483648)
               integ_in = 32'sh80000000;
            else
               integ_in = integ_sum[31:0];
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done)
               state_in = ST_MP;
         end
         ST_MP: begin
            prod_in  = mul_p;
            state_in = ST_MI;
         end
         ST_MI: begin
            acc_in   = 50'(prod_ff);
            prod_in  = mul_p;
            state_in = ST_MD;
         end
         ST_MD: begin
            acc_in   = acc_ff + 50'(prod_ff);
            prod_in  = mul_p;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            acc_in   = acc_ff + 50'(prod_ff);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_load) begin
               if (ctl > 43'(out_upper_ff))
                  rsp_data_in = out_upper_ff;
               else if (ctl < 43'(out_lower_ff))
                  rsp_data_in = out_lower_ff;
               else
                  rsp_data_in = ctl[15:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      err_ff      <= err_in;
      dt_ff       <= dt_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         prev_err_ff   <= '0;
         integ_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         gain_prop_ff  <= '0;
         gain_integ_ff <= '0;
         gain_deriv_ff <= '0;
         out_upper_ff  <= 16'sh7fff;
         out_lower_ff  <= 16'sh8000;
      end else begin
         state_ff     <= state_in;
         prev_err_ff  <= prev_err_in;
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               pidc_pkg::REG_GAIN_PROP:  gain_prop_ff  <= $signed(csr_data);
               pidc_pkg::REG_GAIN_INTEG: gain_integ_ff <= $signed(csr_data);
               pidc_pkg::REG_GAIN_DERIV: gain_deriv_ff <= $signed(csr_data);
               pidc_pkg::REG_OUT_UPPER:  out_upper_ff  <= $signed(csr_data);
               pidc_pkg::REG_OUT_LOWER:  out_lower_ff  <= $signed(csr_data);
               default: ;
            endcase
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[src/pidc_div.sv]
module pidc_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [pidc_pkg::DivW-1:0]       num,
   input  logic [15:0]                     den,
   output logic [pidc_pkg::DivW-1:0]       quot,
   output pidc_pkg::div_status_type        status
);

   logic [pidc_pkg::DivW-1:0]    work_ff, work_in;
   logic [15:0]                  rem_ff, rem_in;
   logic [15:0]                  den_ff, den_in;
   logic [pidc_pkg::DivCntW-1:0] cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [16:0]                  trial;
   logic                         fits;

   // restoring division, one quotient bit per cycle, MSB first
   assign trial = {rem_ff, work_ff[pidc_pkg::DivW-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = pidc_pkg::DivCntW'(pidc_pkg::DivW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? 16'(trial - {1'b0, den_ff}) : trial[15:0];
         work_in = {work_ff[pidc_pkg::DivW-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quot        = work_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

[src/pidc_checker.sv]
module pidc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        csr_ready
);

   // a held result word does not change until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   // a word in work blocks the input for the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req taken twice back to back");

   // reset leaves the block idle with no pending result
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("not idle after reset");

   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr channel stalled");

endmodule

bind pid_controller_clamped pidc_checker u_pidc_checker (.*);
